// File: hw/rtl/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared widths, register map, sequencer states and divider status for the
// k-means clustering block.
// ----------------------------------------------------------------------------
package kmc_pkg;

  // field and register widths
  localparam int CRD_W = 16;
  localparam int ASG_W = 3;
  localparam int IDX_W = 3;
  localparam int NP_W  = 11;
  localparam int ND_W  = 4;
  localparam int NK_W  = 4;
  localparam int NI_W  = 8;
  localparam int LC_W  = 14;
  localparam int SQ_W  = 33;
  localparam int ACC_W = 36;
  localparam int PA_W  = 4;
  localparam int PD_W  = 32;

  // default sizes
  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_DIMS_DEF     = 8;
  localparam int MAX_CLUSTERS_DEF = 8;

  // register reset values
  localparam logic [NP_W-1:0] NP_RST = 11'd1024;
  localparam logic [ND_W-1:0] ND_RST = 4'd2;
  localparam logic [NK_W-1:0] NK_RST = 4'd2;
  localparam logic [NI_W-1:0] NI_RST = 8'd100;

  // register indexes
  typedef enum logic [1:0] {
    REG_NUM_POINTS,
    REG_NUM_DIMS,
    REG_NUM_CLUSTERS,
    REG_NUM_ITERS
  } kmc_reg_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_RECALC,
    ST_RECALC_WAIT,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_A_RD,
    ST_A_SQ,
    ST_A_ACC,
    ST_CLR,
    ST_S_RDA,
    ST_S_ASG,
    ST_S_RD,
    ST_S_ADD,
    ST_U_CHK,
    ST_U_RD,
    ST_U_DIV0,
    ST_U_DIV,
    ST_O_RD,
    ST_O_LD
  } kmc_state_e;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } kmc_div_sts_t;

endpackage

// File: hw/rtl/kmc_if.sv
// ----------------------------------------------------------------------------
// kmc_if
// Valid/ready channels for coordinates in and centroid coordinates out.
// ----------------------------------------------------------------------------
interface kmc_in_if;
  import kmc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] coord;
  modport source (output valid, output coord, input ready);
  modport sink (input valid, input coord, output ready);
endinterface

interface kmc_out_if;
  import kmc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] centroid_coord;
  logic [IDX_W-1:0]        cluster_index;
  logic [IDX_W-1:0]        dim_index;
  logic                    last;
  modport source (output valid, output centroid_coord, output cluster_index,
                  output dim_index, output last, input ready);
  modport sink (input valid, input centroid_coord, input cluster_index,
                input dim_index, input last, output ready);
endinterface

// File: hw/rtl/kmc_ram.sv
// ----------------------------------------------------------------------------
// kmc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: hw/rtl/kmc_div.sv
// ----------------------------------------------------------------------------
// kmc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmc_div #(
  parameter int DVW = 26,
  parameter int DSW = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVW-1:0]       dividend_i,
  input  logic [DSW-1:0]       divisor_i,
  output logic [DVW-1:0]       quotient_o,
  output logic [DSW-1:0]       remainder_o,
  output kmc_pkg::kmc_div_sts_t sts_o
);
  import kmc_pkg::*;

  localparam int CW = $clog2(DVW + 1);

  logic [CW-1:0]  cnt_q, cnt_d;
  logic           done_q, done_d;
  logic [DVW-1:0] quo_q, quo_d;
  logic [DSW-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [DSW:0]   rem_sh;
  logic           ge;

  // one shift and trial subtract per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DVW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = CW'(DVW);
    end else if (cnt_q != '0) begin
      quo_d  = {quo_q[DVW-2:0], ge};
      rem_d  = ge ? DSW'(rem_sh - {1'b0, dsr_q}) : DSW'(rem_sh);
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign sts_o.busy  = (cnt_q != '0);
  assign sts_o.done  = done_q;

  `ifndef NO_ASSERTIONS
  // checks that no division is started while one is running
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !sts_o.busy) else $error("divider restarted while busy");
  // done follows the last step
  a_done_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CW'(1) && !start_i) |=> done_q) else $error("divider done missing");
  // done only when idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0) else $error("divider done while busy");
  `endif
endmodule

// File: hw/rtl/kmeans_clustering.sv
// ----------------------------------------------------------------------------
// kmeans_clustering
// Lloyd k-means over signed Q8.8 points held in on-chip RAM.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      handshake
//  pt_i      in   coord                                        valid/ready
//  cent_o    out  centroid_coord, cluster_index, dim_index,    valid/ready
//                 last
//  apb       in   num_points, num_dims, num_clusters, num_iter psel/penable
//
//  Loading takes one coordinate per cycle into the point RAM while ready is high.
//  Clustering seeds the centroids from the first k points, then runs the passes,
//  bound by the single read port of each RAM and the bit-serial divider; each
//  result is then read from the centroid RAM and loaded into the output register.
//  Writing num_dims during a load runs a divider pass to re-split the coordinate
//  count, with coordinate input held off.
//  A result waiting in the output register does not stop the next load.
//  Reset clears the load counter and control registers; RAMs are not cleared.
// ----------------------------------------------------------------------------
module kmeans_clustering #(
  parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS     = kmc_pkg::MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  kmc_in_if.sink                   pt_i,
  kmc_out_if.source                cent_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [kmc_pkg::PA_W-1:0] paddr,
  input  logic [kmc_pkg::PD_W-1:0] pwdata,
  output logic [kmc_pkg::PD_W-1:0] prdata,
  output logic                     pready
);
  import kmc_pkg::*;

  localparam int PDEPTH = MAX_POINTS * MAX_DIMS;
  localparam int PAW    = ($clog2(PDEPTH) > 0) ? $clog2(PDEPTH) : 1;
  localparam int CDEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int CAW    = ($clog2(CDEPTH) > 0) ? $clog2(CDEPTH) : 1;
  localparam int PIW    = ($clog2(MAX_POINTS) > 0) ? $clog2(MAX_POINTS) : 1;
  localparam int NW     = $clog2(MAX_POINTS + 1);
  localparam int KIW    = ($clog2(MAX_CLUSTERS) > 0) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW     = $clog2(MAX_CLUSTERS + 1);
  localparam int DIW    = ($clog2(MAX_DIMS) > 0) ? $clog2(MAX_DIMS) : 1;
  localparam int DW     = $clog2(MAX_DIMS + 1);
  localparam int SW     = CRD_W + $clog2(MAX_POINTS);
  localparam int DSW    = (NW > DW) ? NW : DW;

  // configuration registers
  logic [NP_W-1:0] np_q;
  logic [ND_W-1:0] nd_q;
  logic [NK_W-1:0] nk_q;
  logic [NI_W-1:0] ni_q;
  logic            cfg_wr;
  kmc_reg_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = kmc_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= NP_RST;
      nd_q <= ND_RST;
      nk_q <= NK_RST;
      ni_q <= NI_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NUM_POINTS:   np_q <= pwdata[NP_W-1:0];
        REG_NUM_DIMS:     nd_q <= pwdata[ND_W-1:0];
        REG_NUM_CLUSTERS: nk_q <= pwdata[NK_W-1:0];
        REG_NUM_ITERS:    ni_q <= pwdata[NI_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_NUM_POINTS:   prdata = PD_W'(np_q);
      REG_NUM_DIMS:     prdata = PD_W'(nd_q);
      REG_NUM_CLUSTERS: prdata = PD_W'(nk_q);
      REG_NUM_ITERS:    prdata = PD_W'(ni_q);
      default:          prdata = '0;
    endcase
  end

  // effective sizes after clamping
  logic [NW-1:0] n_eff;
  logic [DW-1:0] d_eff;
  logic [KW-1:0] k_eff;
  int            kc;
  always_comb begin
    kc = 0;
    if (np_q == '0) n_eff = NW'(1);
    else if (int'(np_q) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
    else n_eff = NW'(np_q);
    if (nd_q == '0) d_eff = DW'(1);
    else if (int'(nd_q) > MAX_DIMS) d_eff = DW'(MAX_DIMS);
    else d_eff = DW'(nd_q);
    if (nk_q == '0) kc = 1;
    else if (int'(nk_q) > MAX_CLUSTERS) kc = MAX_CLUSTERS;
    else kc = int'(nk_q);
    if (kc > int'(n_eff)) kc = int'(n_eff);
    k_eff = KW'(kc);
  end

  // sequencer and datapath registers
  kmc_state_e               state_q, state_d;
  logic [LC_W-1:0]          lcnt_q, lcnt_d, lpt_q, lpt_d;
  logic [DIW-1:0]           ldim_q, ldim_d;
  logic [NI_W-1:0]          it_q, it_d;
  logic [NW-1:0]            p_q, p_d;
  logic [KW-1:0]            c_q, c_d;
  logic [DW-1:0]            j_q, j_d;
  logic [CAW-1:0]           clr_q, clr_d;
  logic [ACC_W-1:0]         acc_q, acc_d, best_q, best_d;
  logic [ASG_W-1:0]         bestc_q, bestc_d, asg_q, asg_d;
  logic [SQ_W-1:0]          sq_q, sq_d;
  logic                     neg_q, neg_d;
  logic                     ov_q, ov_d, olast_q, olast_d;
  logic signed [CRD_W-1:0]  ocrd_q, ocrd_d;
  logic [IDX_W-1:0]         ocl_q, ocl_d, odim_q, odim_d;

  // member counts
  logic [NW-1:0]            mcnt_q [MAX_CLUSTERS];
  logic [KIW-1:0]           cidx;
  logic [NW-1:0]            mcnt_rd;
  logic                     u_phase;

  // RAM ports
  logic                     p_we, c_we, a_we, s_we;
  logic [PAW-1:0]           p_waddr, p_raddr;
  logic [CAW-1:0]           c_addr, s_waddr, s_raddr;
  logic [PIW-1:0]           a_addr;
  logic [CRD_W-1:0]         p_rdata, c_rdata, c_wdata;
  logic [ASG_W-1:0]         a_rdata, a_wdata;
  logic [SW-1:0]            s_rdata, s_wdata;
  logic signed [CRD_W-1:0]  prd, crd;
  logic signed [SW-1:0]     srd;

  // divider
  logic                     dv_start;
  logic [SW-1:0]            dv_dividend, dv_quo;
  logic [DSW-1:0]           dv_divisor, dv_rem;
  kmc_div_sts_t             dv_sts;

  // combinational helpers
  logic                     in_acc;
  logic [LC_W:0]            lcnt_inc;
  logic signed [CRD_W:0]    diff;
  logic signed [2*CRD_W+1:0] prod;
  logic [ACC_W-1:0]         accn;
  logic                     better;
  logic [ASG_W-1:0]         nbc;
  logic [SW-1:0]            mag;
  logic [CRD_W-1:0]         mean;
  logic                     j_last, c_last, p_last;

  assign prd = $signed(p_rdata);
  assign crd = $signed(c_rdata);
  assign srd = $signed(s_rdata);

  assign pt_i.ready = (state_q == ST_LOAD);
  assign in_acc     = pt_i.valid && pt_i.ready;

  // one count read port, cluster under update or cluster of current point
  assign u_phase = (state_q == ST_U_CHK) || (state_q == ST_U_RD) ||
                   (state_q == ST_U_DIV0) || (state_q == ST_U_DIV);
  assign cidx    = u_phase ? c_q[KIW-1:0] : asg_q[KIW-1:0];
  assign mcnt_rd = mcnt_q[cidx];

  // RAM addressing
  assign p_we    = in_acc && (int'(lpt_q) < MAX_POINTS);
  assign p_waddr = PAW'(int'(lpt_q) * MAX_DIMS + int'(ldim_q));
  assign p_raddr = ((state_q == ST_SEED_RD) || (state_q == ST_SEED_WR)) ?
                   PAW'(int'(c_q) * MAX_DIMS + int'(j_q)) :
                   PAW'(int'(p_q) * MAX_DIMS + int'(j_q));
  assign c_addr  = CAW'(int'(c_q) * MAX_DIMS + int'(j_q));
  assign a_addr  = p_q[PIW-1:0];
  assign s_raddr = u_phase ? c_addr : CAW'(int'(asg_q) * MAX_DIMS + int'(j_q));
  assign s_waddr = (state_q == ST_CLR) ? clr_q : s_raddr;

  assign j_last = (int'(j_q) + 1 >= int'(d_eff));
  assign c_last = (int'(c_q) + 1 >= int'(k_eff));
  assign p_last = (int'(p_q) + 1 >= int'(n_eff));

  // distance, sum and rounded-mean arithmetic
  always_comb begin
    lcnt_inc = {1'b0, lcnt_q} + (LC_W + 1)'(1);
    diff     = (CRD_W + 1)'(prd) - (CRD_W + 1)'(crd);
    prod     = diff * diff;
    sq_d     = SQ_W'(prod);
    accn     = acc_q + ACC_W'(sq_q);
    better   = (c_q == '0) || (accn < best_q);
    nbc      = better ? ASG_W'(c_q) : bestc_q;
    mag      = srd[SW-1] ? (SW'(0) - SW'(srd)) : SW'(srd);
    if (neg_q) begin
      mean = (dv_quo > SW'(32768)) ? 16'h8000 : CRD_W'(SW'(0) - dv_quo);
    end else begin
      mean = (dv_quo > SW'(32767)) ? 16'h7fff : CRD_W'(dv_quo);
    end
  end

  assign c_we    = (state_q == ST_SEED_WR) || ((state_q == ST_U_DIV) && dv_sts.done);
  assign c_wdata = (state_q == ST_SEED_WR) ? p_rdata : mean;
  assign a_we    = (state_q == ST_A_ACC) && j_last && c_last;
  assign a_wdata = nbc;
  assign s_we    = (state_q == ST_CLR) || (state_q == ST_S_ADD);
  assign s_wdata = (state_q == ST_CLR) ? '0 : SW'(srd + SW'(prd));

  assign dv_start    = (state_q == ST_RECALC) || (state_q == ST_U_DIV0);
  assign dv_dividend = (state_q == ST_RECALC) ? SW'(lcnt_q) :
                       SW'(mag + SW'(mcnt_rd >> 1));
  assign dv_divisor  = (state_q == ST_RECALC) ? DSW'(d_eff) : DSW'(mcnt_rd);

  // next state and datapath
  always_comb begin
    state_d = state_q;
    lcnt_d  = lcnt_q;
    lpt_d   = lpt_q;
    ldim_d  = ldim_q;
    it_d    = it_q;
    p_d     = p_q;
    c_d     = c_q;
    j_d     = j_q;
    clr_d   = clr_q;
    acc_d   = acc_q;
    best_d  = best_q;
    bestc_d = bestc_q;
    asg_d   = asg_q;
    neg_d   = neg_q;
    ov_d    = ov_q;
    olast_d = olast_q;
    ocrd_d  = ocrd_q;
    ocl_d   = ocl_q;
    odim_d  = odim_q;

    if (cent_o.valid && cent_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (int'(lcnt_inc) >= int'(n_eff) * int'(d_eff)) begin
            lcnt_d  = '0;
            lpt_d   = '0;
            ldim_d  = '0;
            c_d     = '0;
            j_d     = '0;
            state_d = ST_SEED_RD;
          end else begin
            lcnt_d = lcnt_inc[LC_W-1:0];
            if (int'(ldim_q) + 1 >= int'(d_eff)) begin
              ldim_d = '0;
              lpt_d  = lpt_q + LC_W'(1);
            end else begin
              ldim_d = ldim_q + DIW'(1);
            end
          end
        end
      end
      ST_RECALC: state_d = ST_RECALC_WAIT;
      ST_RECALC_WAIT: begin
        if (dv_sts.done) begin
          lpt_d   = dv_quo[LC_W-1:0];
          ldim_d  = dv_rem[DIW-1:0];
          state_d = ST_LOAD;
        end
      end
      // copy the first k points into the centroid RAM
      ST_SEED_RD: state_d = ST_SEED_WR;
      ST_SEED_WR: begin
        state_d = ST_SEED_RD;
        if (!j_last) begin
          j_d = j_q + DW'(1);
        end else begin
          j_d = '0;
          if (!c_last) begin
            c_d = c_q + KW'(1);
          end else begin
            c_d   = '0;
            p_d   = '0;
            it_d  = '0;
            acc_d = '0;
            state_d = (ni_q == '0) ? ST_O_RD : ST_A_RD;
          end
        end
      end
      // nearest centroid search
      ST_A_RD: state_d = ST_A_SQ;
      ST_A_SQ: state_d = ST_A_ACC;
      ST_A_ACC: begin
        state_d = ST_A_RD;
        if (!j_last) begin
          j_d   = j_q + DW'(1);
          acc_d = accn;
        end else begin
          j_d     = '0;
          acc_d   = '0;
          best_d  = better ? accn : best_q;
          bestc_d = nbc;
          if (!c_last) begin
            c_d = c_q + KW'(1);
          end else begin
            c_d = '0;
            if (!p_last) begin
              p_d = p_q + NW'(1);
            end else begin
              p_d     = '0;
              clr_d   = '0;
              state_d = ST_CLR;
            end
          end
        end
      end
      // clear the sums
      ST_CLR: begin
        if (int'(clr_q) >= CDEPTH - 1) state_d = ST_S_RDA;
        else clr_d = clr_q + CAW'(1);
      end
      // accumulate members
      ST_S_RDA: state_d = ST_S_ASG;
      ST_S_ASG: begin
        asg_d   = a_rdata;
        j_d     = '0;
        state_d = ST_S_RD;
      end
      ST_S_RD: state_d = ST_S_ADD;
      ST_S_ADD: begin
        if (!j_last) begin
          j_d     = j_q + DW'(1);
          state_d = ST_S_RD;
        end else begin
          j_d = '0;
          if (!p_last) begin
            p_d     = p_q + NW'(1);
            state_d = ST_S_RDA;
          end else begin
            p_d     = '0;
            c_d     = '0;
            state_d = ST_U_CHK;
          end
        end
      end
      // new centroids from the sums
      ST_U_CHK: begin
        j_d = '0;
        if (int'(c_q) >= int'(k_eff)) begin
          c_d = '0;
          if (int'(it_q) + 1 < int'(ni_q)) begin
            it_d    = it_q + NI_W'(1);
            state_d = ST_A_RD;
          end else begin
            state_d = ST_O_RD;
          end
        end else if (mcnt_rd == '0) begin
          c_d = c_q + KW'(1);
        end else begin
          state_d = ST_U_RD;
        end
      end
      ST_U_RD: state_d = ST_U_DIV0;
      ST_U_DIV0: begin
        neg_d   = srd[SW-1];
        state_d = ST_U_DIV;
      end
      ST_U_DIV: begin
        if (dv_sts.done) begin
          if (!j_last) begin
            j_d     = j_q + DW'(1);
            state_d = ST_U_RD;
          end else begin
            j_d     = '0;
            c_d     = c_q + KW'(1);
            state_d = ST_U_CHK;
          end
        end
      end
      // hand out the centroids
      ST_O_RD: state_d = ST_O_LD;
      ST_O_LD: begin
        if (!ov_q || cent_o.ready) begin
          ov_d    = 1'b1;
          ocrd_d  = crd;
          ocl_d   = IDX_W'(c_q);
          odim_d  = IDX_W'(j_q);
          olast_d = j_last && c_last;
          state_d = ST_O_RD;
          if (!j_last) begin
            j_d = j_q + DW'(1);
          end else begin
            j_d = '0;
            if (!c_last) begin
              c_d = c_q + KW'(1);
            end else begin
              c_d     = '0;
              state_d = ST_LOAD;
            end
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase

    // a new dimension count written while loading re-splits the coordinate count
    if (cfg_wr && (cfg_idx == REG_NUM_DIMS) &&
        ((state_q == ST_LOAD) || (state_q == ST_RECALC) ||
         (state_q == ST_RECALC_WAIT))) begin
      state_d = ST_RECALC;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      lcnt_q  <= '0;
      lpt_q   <= '0;
      ldim_q  <= '0;
      it_q    <= '0;
      p_q     <= '0;
      c_q     <= '0;
      j_q     <= '0;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      lpt_q   <= lpt_d;
      ldim_q  <= ldim_d;
      it_q    <= it_d;
      p_q     <= p_d;
      c_q     <= c_d;
      j_q     <= j_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    best_q  <= best_d;
    bestc_q <= bestc_d;
    asg_q   <= asg_d;
    sq_q    <= sq_d;
    neg_q   <= neg_d;
    olast_q <= olast_d;
    ocrd_q  <= ocrd_d;
    ocl_q   <= ocl_d;
    odim_q  <= odim_d;
  end

  // member counts, cleared with the sums
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLR) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        mcnt_q[i] <= '0;
      end
    end else if (state_q == ST_S_RD && j_q == '0) begin
      mcnt_q[cidx] <= mcnt_rd + NW'(1);
    end
  end

  assign cent_o.valid          = ov_q;
  assign cent_o.centroid_coord = ocrd_q;
  assign cent_o.cluster_index  = ocl_q;
  assign cent_o.dim_index      = odim_q;
  assign cent_o.last           = olast_q;

  // point RAM
  kmc_ram #(.WIDTH(CRD_W), .DEPTH(PDEPTH)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (pt_i.coord),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // centroid RAM
  kmc_ram #(.WIDTH(CRD_W), .DEPTH(CDEPTH)) u_cent_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_addr),
    .wdata_i (c_wdata),
    .raddr_i (c_addr),
    .rdata_o (c_rdata)
  );

  // assignment RAM
  kmc_ram #(.WIDTH(ASG_W), .DEPTH(MAX_POINTS)) u_asg_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_addr),
    .wdata_i (a_wdata),
    .raddr_i (a_addr),
    .rdata_o (a_rdata)
  );

  // sum RAM
  kmc_ram #(.WIDTH(SW), .DEPTH(CDEPTH)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // shared divider for means and the load re-split
  kmc_div #(.DVW(SW), .DSW(DSW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dv_start),
    .dividend_i  (dv_dividend),
    .divisor_i   (dv_divisor),
    .quotient_o  (dv_quo),
    .remainder_o (dv_rem),
    .sts_o       (dv_sts)
  );

  `ifndef NO_ASSERTIONS
  // assignments always name a live centroid
  a_asg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_we |-> int'(a_wdata) < int'(k_eff)) else $error("assignment out of range");
  // last marks the final centroid coordinate
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cent_o.valid && cent_o.last) |->
    (int'(cent_o.cluster_index) + 1 == int'(k_eff)) &&
    (int'(cent_o.dim_index) + 1 == int'(d_eff))) else $error("misplaced last");
  // a mean is only taken for a cluster that has members
  a_nonzero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_U_DIV0) |-> mcnt_rd != '0) else $error("mean of empty cluster");
  // the sequencer waits in ST_O_LD while a result in the output register is not taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cent_o.valid && !cent_o.ready && state_q == ST_O_LD) |=> state_q == ST_O_LD)
    else $error("output overwritten");
  `endif
endmodule
